// ===== rtl/core/hdpd_pkg.sv =====
// Package for the dual-mode heading PID drive unit.
// Holds fixed-point widths, limits, register codes and stage structs.
// No dependencies; every other file imports it.
`default_nettype none

package hdpd_pkg;

    localparam int ANGLE_FRAC_BITS = 8;
    localparam int GAIN_FRAC_BITS  = 12;

    localparam int YAW_W   = 17;
    localparam int ERR_W   = YAW_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int SSUM_W  = 32;
    localparam int TSUM_W  = 19;
    localparam int GAIN_W  = 16;
    localparam int SPEED_W = 7;
    localparam int OUT_W   = 16;
    localparam int IDX_W   = 3;

    localparam int P_W   = GAIN_W + 1 + ERR_W;
    localparam int I_W   = GAIN_W + 1 + SSUM_W;
    localparam int D_W   = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W = I_W + 2;
    localparam int PID_W = 14;
    localparam int SPD_W = 18;

    localparam int STRAIGHT_DEADBAND = 1 << (ANGLE_FRAC_BITS - 1);
    localparam int SPIN_DEADBAND     = 1 << ANGLE_FRAC_BITS;
    localparam int SPIN_WINDOW       = 30 << ANGLE_FRAC_BITS;
    localparam int SPIN_SUM_LIMIT    = 1000 << ANGLE_FRAC_BITS;
    localparam int STRAIGHT_LIMIT    = 10;
    localparam int SPIN_LIMIT        = 13;

    typedef enum logic {
        LOOP_STRAIGHT = 1'b0,
        LOOP_SPIN     = 1'b1
    } loop_t;

    typedef enum logic [IDX_W-1:0] {
        REG_KP_STRAIGHT = 3'd0,
        REG_KI_STRAIGHT = 3'd1,
        REG_KD_STRAIGHT = 3'd2,
        REG_KP_SPIN     = 3'd3,
        REG_KI_SPIN     = 3'd4,
        REG_KD_SPIN     = 3'd5,
        REG_CRUISE      = 3'd6,
        REG_SPIN_SPEED  = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  kp_straight;
        logic [GAIN_W-1:0]  ki_straight;
        logic [GAIN_W-1:0]  kd_straight;
        logic [GAIN_W-1:0]  kp_spin;
        logic [GAIN_W-1:0]  ki_spin;
        logic [GAIN_W-1:0]  kd_spin;
        logic [SPEED_W-1:0] cruise_speed;
        logic [SPEED_W-1:0] spin_speed;
    } gains_t;

    localparam gains_t GAINS_RESET = '{
        kp_straight:  16'd9380,
        ki_straight:  16'd725,
        kd_straight:  16'd8192,
        kp_spin:      16'd287,
        ki_spin:      16'd0,
        kd_spin:      16'd246,
        cruise_speed: 7'd70,
        spin_speed:   7'd20
    };

    typedef struct packed {
        loop_t                     mode;
        logic                      emit_ok;
        logic signed [ERR_W-1:0]   err;
        logic signed [DIFF_W-1:0]  diff;
        logic signed [SSUM_W-1:0]  sum;
    } err_stage_t;

    typedef struct packed {
        loop_t                     mode;
        logic                      emit_ok;
        logic signed [P_W-1:0]     prod_p;
        logic signed [I_W-1:0]     prod_i;
        logic signed [D_W-1:0]     prod_d;
    } prod_stage_t;

endpackage

`default_nettype wire

// ===== rtl/core/hdpd_state.sv =====
// Loop state and error stage: per-mode target, previous error and error sum.
// Forms error, derivative term and the new sum for each accepted item.
// Depends on hdpd_pkg.
`default_nettype none

module hdpd_state (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          yaw_valid,
    output logic                               yaw_ready,
    input  wire logic                          run_enable,
    input  wire logic                          req_type,
    input  wire logic                          loop_clear,
    input  wire logic                          capture_target,
    input  wire logic signed [hdpd_pkg::YAW_W-1:0] yaw_angle,
    input  wire logic                          down_ready,
    output logic                               stage_valid,
    output hdpd_pkg::err_stage_t               stage_data
);
    import hdpd_pkg::*;

    localparam logic signed [ERR_W-1:0]  STR_DB_HI = ERR_W'(STRAIGHT_DEADBAND);
    localparam logic signed [ERR_W-1:0]  STR_DB_LO = -ERR_W'(STRAIGHT_DEADBAND);
    localparam logic signed [ERR_W-1:0]  SPN_DB_HI = ERR_W'(SPIN_DEADBAND);
    localparam logic signed [ERR_W-1:0]  SPN_DB_LO = -ERR_W'(SPIN_DEADBAND);
    localparam logic signed [ERR_W-1:0]  WIN_HI    = ERR_W'(SPIN_WINDOW);
    localparam logic signed [ERR_W-1:0]  WIN_LO    = -ERR_W'(SPIN_WINDOW);
    localparam logic signed [TSUM_W:0]   TSUM_HI   = (TSUM_W+1)'(SPIN_SUM_LIMIT);
    localparam logic signed [TSUM_W:0]   TSUM_LO   = -(TSUM_W+1)'(SPIN_SUM_LIMIT);

    logic signed [YAW_W-1:0]  straight_target_reg, spin_target_reg;
    logic signed [ERR_W-1:0]  straight_prev_reg, spin_prev_reg;
    logic signed [SSUM_W-1:0] straight_sum_reg;
    logic signed [TSUM_W-1:0] spin_sum_reg;
    logic                     valid_reg;
    err_stage_t               data_reg;

    loop_t                    mode;
    logic                     take;
    logic signed [YAW_W-1:0]  tgt_eff;
    logic signed [ERR_W-1:0]  prev_eff;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SSUM_W-1:0] ssum_eff, ssum_next;
    logic signed [SSUM_W:0]   ssum_wide;
    logic signed [TSUM_W-1:0] tsum_eff, tsum_next;
    logic signed [TSUM_W:0]   tsum_wide;
    logic                     emit_ok;

    assign yaw_ready   = !valid_reg || down_ready;
    assign take        = yaw_valid && yaw_ready && run_enable;
    assign mode        = loop_t'(req_type);
    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

    always_comb
    begin
        if (capture_target)
        begin
            tgt_eff = yaw_angle;
        end
        else if (loop_clear)
        begin
            tgt_eff = '0;
        end
        else
        begin
            tgt_eff = (mode == LOOP_SPIN) ? spin_target_reg : straight_target_reg;
        end
        if (loop_clear)
        begin
            prev_eff = '0;
        end
        else
        begin
            prev_eff = (mode == LOOP_SPIN) ? spin_prev_reg : straight_prev_reg;
        end
        ssum_eff = loop_clear ? '0 : straight_sum_reg;
        tsum_eff = loop_clear ? '0 : spin_sum_reg;

        err  = ERR_W'(tgt_eff) - ERR_W'(yaw_angle);
        diff = DIFF_W'(err) - DIFF_W'(prev_eff);

        ssum_wide = (SSUM_W+1)'(ssum_eff) + (SSUM_W+1)'(err);
        if (ssum_wide[SSUM_W] != ssum_wide[SSUM_W-1])
        begin
            ssum_next = ssum_wide[SSUM_W] ? {1'b1, {(SSUM_W-1){1'b0}}}
                                          : {1'b0, {(SSUM_W-1){1'b1}}};
        end
        else
        begin
            ssum_next = ssum_wide[SSUM_W-1:0];
        end

        tsum_wide = (TSUM_W+1)'(tsum_eff) + (TSUM_W+1)'(err);
        if (!(err < WIN_HI && err > WIN_LO))
        begin
            tsum_next = '0;
        end
        else if (tsum_wide > TSUM_HI)
        begin
            tsum_next = TSUM_HI[TSUM_W-1:0];
        end
        else if (tsum_wide < TSUM_LO)
        begin
            tsum_next = TSUM_LO[TSUM_W-1:0];
        end
        else
        begin
            tsum_next = tsum_wide[TSUM_W-1:0];
        end

        if (mode == LOOP_SPIN)
        begin
            emit_ok = (err > SPN_DB_HI) || (err < SPN_DB_LO);
        end
        else
        begin
            emit_ok = (err > STR_DB_HI) || (err < STR_DB_LO);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            straight_target_reg <= '0;
            straight_prev_reg   <= '0;
            straight_sum_reg    <= '0;
            spin_target_reg     <= '0;
            spin_prev_reg       <= '0;
            spin_sum_reg        <= '0;
            valid_reg           <= 1'b0;
        end
        else
        begin
            if (take && mode == LOOP_STRAIGHT)
            begin
                straight_target_reg <= tgt_eff;
                straight_prev_reg   <= err;
                straight_sum_reg    <= ssum_next;
            end
            if (take && mode == LOOP_SPIN)
            begin
                spin_target_reg <= tgt_eff;
                spin_prev_reg   <= err;
                spin_sum_reg    <= tsum_next;
            end
            if (yaw_ready)
            begin
                valid_reg <= take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg.mode    <= mode;
            data_reg.emit_ok <= emit_ok;
            data_reg.err     <= err;
            data_reg.diff    <= diff;
            data_reg.sum     <= (mode == LOOP_SPIN) ? SSUM_W'(tsum_next) : ssum_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hdpd_mult.sv =====
// Product stage: the three PID gain multiplies, registered.
// Gains are picked by the item's loop.
// Depends on hdpd_pkg.
`default_nettype none

module hdpd_mult (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hdpd_pkg::gains_t     gains,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire hdpd_pkg::err_stage_t up_data,
    input  wire logic                 down_ready,
    output logic                      stage_valid,
    output hdpd_pkg::prod_stage_t     stage_data
);
    import hdpd_pkg::*;

    logic                      valid_reg;
    prod_stage_t               data_reg;
    logic signed [GAIN_W:0]    kp, ki, kd;

    assign up_ready    = !valid_reg || down_ready;
    assign stage_valid = valid_reg;
    assign stage_data  = data_reg;

    always_comb
    begin
        if (up_data.mode == LOOP_SPIN)
        begin
            kp = $signed({1'b0, gains.kp_spin});
            ki = $signed({1'b0, gains.ki_spin});
            kd = $signed({1'b0, gains.kd_spin});
        end
        else
        begin
            kp = $signed({1'b0, gains.kp_straight});
            ki = $signed({1'b0, gains.ki_straight});
            kd = $signed({1'b0, gains.kd_straight});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg.mode    <= up_data.mode;
            data_reg.emit_ok <= up_data.emit_ok;
            data_reg.prod_p  <= kp * up_data.err;
            data_reg.prod_i  <= ki * up_data.sum;
            data_reg.prod_d  <= kd * up_data.diff;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hdpd_out.sv =====
// Output stage: PID sum, clamp, floor rounding, wheel mix and saturation.
// Holds the result register toward the command channel.
// Depends on hdpd_pkg.
`default_nettype none

module hdpd_out (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire hdpd_pkg::gains_t       gains,
    input  wire logic                   up_valid,
    output logic                        up_ready,
    input  wire hdpd_pkg::prod_stage_t  up_data,
    output logic                        cmd_valid,
    input  wire logic                   cmd_ready,
    output logic signed [hdpd_pkg::OUT_W-1:0] right_speed,
    output logic signed [hdpd_pkg::OUT_W-1:0] left_speed
);
    import hdpd_pkg::*;

    localparam int LIM_SHIFT = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] STR_LIM = ACC_W'(STRAIGHT_LIMIT) <<< LIM_SHIFT;
    localparam logic signed [ACC_W-1:0] SPN_LIM = ACC_W'(SPIN_LIMIT) <<< LIM_SHIFT;
    localparam logic signed [SPD_W-1:0] OUT_MAX = SPD_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SPD_W-1:0] OUT_MIN = -SPD_W'(1 << (OUT_W - 1));

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SPD_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAX)
        begin
            r = OUT_MAX[OUT_W-1:0];
        end
        else if (v < OUT_MIN)
        begin
            r = OUT_MIN[OUT_W-1:0];
        end
        else
        begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

    logic                     valid_reg;
    logic signed [OUT_W-1:0]  right_reg, left_reg;
    logic signed [ACC_W-1:0]  acc, lim, acc_clamped, acc_shifted;
    logic signed [PID_W-1:0]  pid;
    logic signed [SPD_W-1:0]  base, pid_ext, right_raw, left_raw;
    logic                     emit;

    assign up_ready    = !valid_reg || cmd_ready;
    assign cmd_valid   = valid_reg;
    assign right_speed = right_reg;
    assign left_speed  = left_reg;

    always_comb
    begin
        acc = ACC_W'(up_data.prod_p) + ACC_W'(up_data.prod_i) + ACC_W'(up_data.prod_d);
        lim = (up_data.mode == LOOP_SPIN) ? SPN_LIM : STR_LIM;
        if (acc > lim)
        begin
            acc_clamped = lim;
        end
        else if (acc < -lim)
        begin
            acc_clamped = -lim;
        end
        else
        begin
            acc_clamped = acc;
        end
        acc_shifted = acc_clamped >>> GAIN_FRAC_BITS;
        pid         = acc_shifted[PID_W-1:0];
        pid_ext     = SPD_W'(pid);

        if (up_data.mode == LOOP_SPIN)
        begin
            base = $signed(SPD_W'({gains.spin_speed, {ANGLE_FRAC_BITS{1'b0}}}));
            right_raw = (pid > 0) ? (base + pid_ext) : (pid_ext - base);
            left_raw  = -right_raw;
            emit      = up_data.emit_ok && (pid != '0);
        end
        else
        begin
            base = $signed(SPD_W'({gains.cruise_speed, {ANGLE_FRAC_BITS{1'b0}}}));
            right_raw = base - pid_ext;
            left_raw  = base + pid_ext;
            emit      = up_data.emit_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid && emit)
        begin
            right_reg <= sat_out(right_raw);
            left_reg  <= sat_out(left_raw);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dual_mode_heading_pid_drive_unit.sv =====
// Dual-mode heading PID drive unit, top level: config registers and stage chain.
// Instantiates hdpd_state, hdpd_mult and hdpd_out; depends on hdpd_pkg.
// Usage:
//   Yaw channel (yaw_valid/yaw_ready) carries one yaw sample per item with
//   run_enable, req_type (straight or turn), loop_clear and capture_target.
//   Command channel (cmd_valid/cmd_ready) carries right_speed/left_speed.
//   An item with run_enable low, inside its loop's deadband, or with a zero
//   turn output gives no command; loop state still updates in the latter cases.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes gains and
//   base speeds; cfg_ready is always high. Write only while the unit is idle.
// Timing:
//   One item per cycle is sustained while cmd_ready stays high; loop state
//   closes in the first stage, so back-to-back items on the same loop see
//   each other's updates.
//   Stages: error/state, gain multiplies, PID sum/clamp/mix into result reg.
//   Each stage holds while its successor is full and stalled; yaw_ready stays
//   high while the result register is empty or being taken.
// Reset:
//   rst_n clears all loop state to zero, loads default gains and empties the
//   pipeline; items are accepted right after release.
`default_nettype none

module dual_mode_heading_pid_drive_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 yaw_valid,
    output logic                                      yaw_ready,
    input  wire logic                                 run_enable,
    input  wire logic                                 req_type,
    input  wire logic                                 loop_clear,
    input  wire logic                                 capture_target,
    input  wire logic signed [hdpd_pkg::YAW_W-1:0]    yaw_angle,
    output logic                                      cmd_valid,
    input  wire logic                                 cmd_ready,
    output logic signed [hdpd_pkg::OUT_W-1:0]         right_speed,
    output logic signed [hdpd_pkg::OUT_W-1:0]         left_speed,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [hdpd_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [hdpd_pkg::GAIN_W-1:0]          cfg_data
);
    import hdpd_pkg::*;

    gains_t      gains_reg, gains_next;
    logic        s1_valid, s1_ready;
    err_stage_t  s1_data;
    logic        s2_valid, s2_ready;
    prod_stage_t s2_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KP_STRAIGHT: gains_next.kp_straight  = cfg_data;
                REG_KI_STRAIGHT: gains_next.ki_straight  = cfg_data;
                REG_KD_STRAIGHT: gains_next.kd_straight  = cfg_data;
                REG_KP_SPIN:     gains_next.kp_spin      = cfg_data;
                REG_KI_SPIN:     gains_next.ki_spin      = cfg_data;
                REG_KD_SPIN:     gains_next.kd_spin      = cfg_data;
                REG_CRUISE:      gains_next.cruise_speed = cfg_data[SPEED_W-1:0];
                REG_SPIN_SPEED:  gains_next.spin_speed   = cfg_data[SPEED_W-1:0];
                default:         gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= GAINS_RESET;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    hdpd_state u_state (
        .clk            (clk),
        .rst_n          (rst_n),
        .yaw_valid      (yaw_valid),
        .yaw_ready      (yaw_ready),
        .run_enable     (run_enable),
        .req_type       (req_type),
        .loop_clear     (loop_clear),
        .capture_target (capture_target),
        .yaw_angle      (yaw_angle),
        .down_ready     (s1_ready),
        .stage_valid    (s1_valid),
        .stage_data     (s1_data)
    );

    hdpd_mult u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .gains       (gains_reg),
        .up_valid    (s1_valid),
        .up_ready    (s1_ready),
        .up_data     (s1_data),
        .down_ready  (s2_ready),
        .stage_valid (s2_valid),
        .stage_data  (s2_data)
    );

    hdpd_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .gains       (gains_reg),
        .up_valid    (s2_valid),
        .up_ready    (s2_ready),
        .up_data     (s2_data),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .right_speed (right_speed),
        .left_speed  (left_speed)
    );

endmodule

`default_nettype wire

// ===== rtl/core/hdpd_checker.sv =====
// Port-level checks for the dual-mode heading PID drive unit.
// Bound to dual_mode_heading_pid_drive_unit; depends on hdpd_pkg.
`default_nettype none

module hdpd_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              yaw_ready,
    input  wire logic                              cmd_valid,
    input  wire logic                              cmd_ready,
    input  wire logic signed [hdpd_pkg::OUT_W-1:0] right_speed,
    input  wire logic signed [hdpd_pkg::OUT_W-1:0] left_speed,
    input  wire logic                              cfg_ready
);
    import hdpd_pkg::*;

    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid)
        else $error("cmd_valid dropped while stalled");

    a_cmd_stable: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> $stable(right_speed) && $stable(left_speed))
        else $error("command payload changed while stalled");

    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid || cmd_ready |-> yaw_ready)
        else $error("yaw channel stalled with result register free");

    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config channel not ready");

endmodule

bind dual_mode_heading_pid_drive_unit hdpd_checker u_hdpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .yaw_ready   (yaw_ready),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .right_speed (right_speed),
    .left_speed  (left_speed),
    .cfg_ready   (cfg_ready)
);

`default_nettype wire

// ===== sim/hdpd_checker.sv =====
// Scoreboard for the dual-mode heading PID drive unit: tracks gain writes, predicts
// the wheel commands of every enabled yaw item and compares them in order.
// Depends on hdpd_pkg for widths, limits, loop and register codes.
module hdpd_scoreboard (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  yaw_valid,
    input  logic                                  yaw_ready,
    input  logic                                  run_enable,
    input  logic                                  req_type,
    input  logic                                  loop_clear,
    input  logic                                  capture_target,
    input  logic signed [hdpd_pkg::YAW_W-1:0]     yaw_angle,
    input  logic                                  cmd_valid,
    input  logic                                  cmd_ready,
    input  logic signed [hdpd_pkg::OUT_W-1:0]     right_speed,
    input  logic signed [hdpd_pkg::OUT_W-1:0]     left_speed,
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [hdpd_pkg::IDX_W-1:0]            cfg_index,
    input  logic [hdpd_pkg::GAIN_W-1:0]           cfg_data,
    output int                                    n_errors,
    output int                                    n_due,
    output int                                    n_cmds,
    output int                                    n_runs
);
    import hdpd_pkg::*;

    localparam longint SUM32_MIN = -64'sd2147483648;
    localparam longint SUM32_MAX = 64'sd2147483647;

    typedef struct packed {
        logic signed [OUT_W-1:0] right;
        logic signed [OUT_W-1:0] left;
    } wheel_cmd_t;

    gains_t                    gains;
    logic signed [YAW_W-1:0]   st_target;
    logic signed [ERR_W-1:0]   st_prev;
    logic signed [SSUM_W-1:0]  st_sum;
    logic signed [YAW_W-1:0]   sp_target;
    logic signed [ERR_W-1:0]   sp_prev;
    logic signed [TSUM_W-1:0]  sp_sum;

    wheel_cmd_t wheel_cmds_due[$];
    wheel_cmd_t want;
    wheel_cmd_t fresh;
    int         errs;
    int         cmds;
    int         runs;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Full-precision sum clamped first, then floored to Q.8
    function automatic longint pid_term(input longint kp, input longint ki, input longint kd,
                                        input longint e, input longint prev,
                                        input longint sum, input longint limit);
        longint acc;
        longint lim;
        acc = kp * e + ki * sum + kd * (e - prev);
        lim = limit <<< (ANGLE_FRAC_BITS + GAIN_FRAC_BITS);
        acc = clip(acc, -lim, lim);
        return acc >>> GAIN_FRAC_BITS;
    endfunction

    function automatic logic signed [OUT_W-1:0] wheel_word(input longint v);
        longint c;
        c = clip(v, -longint'(32768), longint'(32767));
        return c[OUT_W-1:0];
    endfunction

    function automatic bit heading_step(input bit clr, input bit cap, input loop_t mode,
                                        input logic signed [YAW_W-1:0] yaw,
                                        output wheel_cmd_t cmd);
        longint y;
        longint e;
        longint s;
        longint o;
        longint base;
        bit     fire;
        y = longint'(yaw);
        cmd = '0;
        if (mode == LOOP_STRAIGHT)
        begin
            if (clr)
            begin
                st_target = '0;
                st_prev   = '0;
                st_sum    = '0;
            end
            if (cap)
                st_target = yaw;
            e = longint'(st_target) - y;
            s = clip(longint'(st_sum) + e, SUM32_MIN, SUM32_MAX);
            st_sum = s[SSUM_W-1:0];
            o = pid_term(longint'(gains.kp_straight), longint'(gains.ki_straight),
                         longint'(gains.kd_straight), e, longint'(st_prev), s,
                         longint'(STRAIGHT_LIMIT));
            st_prev = e[ERR_W-1:0];
            fire = (e > longint'(STRAIGHT_DEADBAND)) || (e < -longint'(STRAIGHT_DEADBAND));
            base = longint'(gains.cruise_speed) <<< ANGLE_FRAC_BITS;
            cmd.right = wheel_word(base - o);
            cmd.left  = wheel_word(base + o);
        end
        else
        begin
            if (clr)
            begin
                sp_target = '0;
                sp_prev   = '0;
                sp_sum    = '0;
            end
            if (cap)
                sp_target = yaw;
            e = longint'(sp_target) - y;
            if (e < longint'(SPIN_WINDOW) && e > -longint'(SPIN_WINDOW))
                s = clip(longint'(sp_sum) + e, -longint'(SPIN_SUM_LIMIT),
                         longint'(SPIN_SUM_LIMIT));
            else
                s = 0;
            sp_sum = s[TSUM_W-1:0];
            o = pid_term(longint'(gains.kp_spin), longint'(gains.ki_spin),
                         longint'(gains.kd_spin), e, longint'(sp_prev), s,
                         longint'(SPIN_LIMIT));
            sp_prev = e[ERR_W-1:0];
            fire = ((e > longint'(SPIN_DEADBAND)) || (e < -longint'(SPIN_DEADBAND)))
                   && (o != 0);
            base = longint'(gains.spin_speed) <<< ANGLE_FRAC_BITS;
            if (o > 0)
            begin
                cmd.right = wheel_word(base + o);
                cmd.left  = wheel_word(-base - o);
            end
            else
            begin
                cmd.right = wheel_word(o - base);
                cmd.left  = wheel_word(base - o);
            end
        end
        return fire;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains     = GAINS_RESET;
            st_target = '0;
            st_prev   = '0;
            st_sum    = '0;
            sp_target = '0;
            sp_prev   = '0;
            sp_sum    = '0;
            wheel_cmds_due.delete();
            errs = 0;
            cmds = 0;
            runs = 0;
            n_errors <= 0;
            n_due    <= 0;
            n_cmds   <= 0;
            n_runs   <= 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                if (wheel_cmds_due.size() == 0)
                begin
                    $error("unexpected command: right_speed %0d left_speed %0d",
                           right_speed, left_speed);
                    errs++;
                end
                else
                begin
                    want = wheel_cmds_due.pop_front();
                    cmds++;
                    if (right_speed !== want.right)
                    begin
                        $error("right_speed: expected %0d, actual %0d",
                               $signed(want.right), right_speed);
                        errs++;
                    end
                    if (left_speed !== want.left)
                    begin
                        $error("left_speed: expected %0d, actual %0d",
                               $signed(want.left), left_speed);
                        errs++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_KP_STRAIGHT: gains.kp_straight  = cfg_data;
                    REG_KI_STRAIGHT: gains.ki_straight  = cfg_data;
                    REG_KD_STRAIGHT: gains.kd_straight  = cfg_data;
                    REG_KP_SPIN:     gains.kp_spin      = cfg_data;
                    REG_KI_SPIN:     gains.ki_spin      = cfg_data;
                    REG_KD_SPIN:     gains.kd_spin      = cfg_data;
                    REG_CRUISE:      gains.cruise_speed = cfg_data[SPEED_W-1:0];
                    REG_SPIN_SPEED:  gains.spin_speed   = cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end

            if (yaw_valid && yaw_ready && run_enable)
            begin
                runs++;
                if (heading_step(loop_clear, capture_target, loop_t'(req_type),
                                 yaw_angle, fresh))
                    wheel_cmds_due.push_back(fresh);
            end

            n_errors <= errs;
            n_due    <= wheel_cmds_due.size();
            n_cmds   <= cmds;
            n_runs   <= runs;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for dual_mode_heading_pid_drive_unit: reset, gain settings, directed
// and random yaw items, random stalls on both channels, and the verdict.
// Depends on hdpd_pkg, the drive unit RTL and hdpd_scoreboard.
module tb_top;
    import hdpd_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int RANDOM_RUNS  = 1000;
    localparam int YAW_LIMIT    = 46080;
    localparam int SWEEP_UP     = 40;
    localparam int SWEEP_DOWN   = 80;
    localparam int DRAIN_CYCLES = 8;

    logic                     clk;
    logic                     rst_n;
    logic                     yaw_valid;
    logic                     yaw_ready;
    logic                     run_enable;
    logic                     req_type;
    logic                     loop_clear;
    logic                     capture_target;
    logic signed [YAW_W-1:0]  yaw_angle;
    logic                     cmd_valid;
    logic                     cmd_ready;
    logic signed [OUT_W-1:0]  right_speed;
    logic signed [OUT_W-1:0]  left_speed;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [IDX_W-1:0]         cfg_index;
    logic [GAIN_W-1:0]        cfg_data;

    int n_errors;
    int n_due;
    int n_cmds;
    int n_runs;
    int cycles;
    int items_sent;
    int settings_used;
    bit calm;

    dual_mode_heading_pid_drive_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .yaw_valid      (yaw_valid),
        .yaw_ready      (yaw_ready),
        .run_enable     (run_enable),
        .req_type       (req_type),
        .loop_clear     (loop_clear),
        .capture_target (capture_target),
        .yaw_angle      (yaw_angle),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .right_speed    (right_speed),
        .left_speed     (left_speed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    hdpd_scoreboard u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .yaw_valid      (yaw_valid),
        .yaw_ready      (yaw_ready),
        .run_enable     (run_enable),
        .req_type       (req_type),
        .loop_clear     (loop_clear),
        .capture_target (capture_target),
        .yaw_angle      (yaw_angle),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .right_speed    (right_speed),
        .left_speed     (left_speed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .n_errors       (n_errors),
        .n_due          (n_due),
        .n_cmds         (n_cmds),
        .n_runs         (n_runs)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // mostly short idles, a few long ones
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int signed_pick(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return GAIN_W'($urandom_range(0, 12000));
            default: return GAIN_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic gains_t random_gains();
        gains_t g;
        g.kp_straight  = pick_gain();
        g.ki_straight  = pick_gain();
        g.kd_straight  = pick_gain();
        g.kp_spin      = pick_gain();
        g.ki_spin      = pick_gain();
        g.kd_spin      = pick_gain();
        g.cruise_speed = SPEED_W'($urandom_range(0, 100));
        g.spin_speed   = SPEED_W'($urandom_range(0, 100));
        return g;
    endfunction

    task automatic push_yaw(input bit en, input loop_t mode, input bit clr, input bit cap,
                            input int yaw);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            yaw_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        yaw_valid      <= 1'b1;
        run_enable     <= en;
        req_type       <= mode;
        loop_clear     <= clr;
        capture_target <= cap;
        yaw_angle      <= yaw[YAW_W-1:0];
        @(posedge clk);
        while (!yaw_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // hold the sender until every expected command is back, then let the pipe empty
    task automatic settle();
        yaw_valid <= 1'b0;
        @(posedge clk);
        while (n_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [GAIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_gains(input gains_t g);
        put_reg(REG_KP_STRAIGHT, g.kp_straight);
        put_reg(REG_KI_STRAIGHT, g.ki_straight);
        put_reg(REG_KD_STRAIGHT, g.kd_straight);
        put_reg(REG_KP_SPIN, g.kp_spin);
        put_reg(REG_KI_SPIN, g.ki_spin);
        put_reg(REG_KD_SPIN, g.kd_spin);
        put_reg(REG_CRUISE, GAIN_W'(g.cruise_speed));
        put_reg(REG_SPIN_SPEED, GAIN_W'(g.spin_speed));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // mostly captured-target runs with random drift, some fully random noise
    task automatic random_block(input int n_runs_wanted);
        int    done;
        int    len;
        int    tgt;
        int    spread;
        int    bias;
        int    jit;
        int    y;
        bit    en;
        loop_t mode;
        done = 0;
        while (done < n_runs_wanted)
        begin
            calm = ($urandom_range(0, 6) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                begin
                    en = 1'($urandom_range(0, 1));
                    push_yaw(en, loop_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), signed_pick(YAW_LIMIT));
                    if (en)
                        done++;
                end
            end
            else
            begin
                mode = loop_t'($urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0:       spread = 384;
                    1:       spread = 2560;
                    2:       spread = 7680;
                    default: spread = 2 * YAW_LIMIT;
                endcase
                tgt  = signed_pick(YAW_LIMIT);
                bias = signed_pick(spread);
                jit  = ($urandom_range(0, 1) == 1) ? 64 : spread;
                push_yaw(1'b1, mode, ($urandom_range(0, 3) == 0), 1'b1, tgt);
                done++;
                len = $urandom_range(4, 60);
                repeat (len)
                begin
                    en = ($urandom_range(0, 19) != 0);
                    y  = tgt - bias + signed_pick(jit);
                    if (y > YAW_LIMIT)
                        y = YAW_LIMIT;
                    if (y < -YAW_LIMIT)
                        y = -YAW_LIMIT;
                    push_yaw(en, mode, 1'b0, 1'b0, y);
                    if (en)
                        done++;
                end
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        int hold;
        hold = 0;
        cmd_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm)
                cmd_ready <= 1'b1;
            else if (hold > 0)
                hold--;
            else if (cmd_ready)
            begin
                cmd_ready <= 1'b0;
                hold = gap_len();
            end
            else
            begin
                cmd_ready <= 1'b1;
                hold = $urandom_range(0, 15);
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        gains_t g;
        rst_n          = 1'b0;
        yaw_valid      = 1'b0;
        run_enable     = 1'b0;
        req_type       = 1'b0;
        loop_clear     = 1'b0;
        capture_target = 1'b0;
        yaw_angle      = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        calm           = 1'b0;
        items_sent     = 0;
        settings_used  = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at reset gains; both loops start with target zero
        push_yaw(1'b0, LOOP_STRAIGHT, 1'b1, 1'b1, YAW_LIMIT);
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b0, 0);
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b0, -128);
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b0, -129);
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b0, 129);
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b1, YAW_LIMIT);
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b0, -YAW_LIMIT);
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b1, 1'b0, YAW_LIMIT);
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b1, 1'b0, 300);
        push_yaw(1'b1, LOOP_SPIN, 1'b1, 1'b0, -256);
        push_yaw(1'b1, LOOP_SPIN, 1'b0, 1'b0, -257);
        push_yaw(1'b1, LOOP_SPIN, 1'b1, 1'b0, -556);
        // derivative cancels proportional: turn output floors to zero
        push_yaw(1'b1, LOOP_SPIN, 1'b0, 1'b0, -257);
        push_yaw(1'b1, LOOP_SPIN, 1'b0, 1'b0, 7679);
        push_yaw(1'b1, LOOP_SPIN, 1'b0, 1'b0, -7680);
        push_yaw(1'b1, LOOP_SPIN, 1'b0, 1'b0, 7680);
        push_yaw(1'b1, LOOP_SPIN, 1'b0, 1'b1, -YAW_LIMIT);
        push_yaw(1'b1, LOOP_SPIN, 1'b0, 1'b0, YAW_LIMIT);
        push_yaw(1'b0, LOOP_SPIN, 1'b1, 1'b0, 0);
        push_yaw(1'b1, LOOP_SPIN, 1'b0, 1'b0, -YAW_LIMIT);
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b0, 1000);
        push_yaw(1'b1, LOOP_SPIN, 1'b1, 1'b1, 12345);
        settle();

        // integral-only straight loop ramped into the output clamp, swung back and up
        g = GAINS_RESET;
        g.kp_straight  = '0;
        g.ki_straight  = 16'd8;
        g.kd_straight  = '0;
        g.cruise_speed = 7'd50;
        load_gains(g);
        calm = 1'b1;
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b1, 1'b1, YAW_LIMIT);
        repeat (SWEEP_UP) push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b0, -YAW_LIMIT);
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b1, -YAW_LIMIT);
        repeat (SWEEP_DOWN) push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b0, YAW_LIMIT);
        push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b1, YAW_LIMIT);
        repeat (SWEEP_UP) push_yaw(1'b1, LOOP_STRAIGHT, 1'b0, 1'b0, -YAW_LIMIT);
        calm = 1'b0;
        settle();

        for (int p = 0; p < 6; p++)
        begin
            g = random_gains();
            case (p)
                0:
                begin
                    g = '1;
                    g.cruise_speed = 7'd100;
                    g.spin_speed   = 7'd100;
                end
                1: g = '0;
                2:
                begin
                    // base speeds past 100 push wheel commands into saturation
                    g.cruise_speed = 7'd127;
                    g.spin_speed   = 7'd127;
                end
                3: g = GAINS_RESET;
                default: ;
            endcase
            load_gains(g);
            random_block(RANDOM_RUNS / 6);
            settle();
        end

        $display("Sent %0d items (%0d enabled) under %0d gain settings, incl. a clamp sweep.",
                 items_sent, n_runs, settings_used);
        $display("Checked %0d wheel commands against the predicted drive outputs.", n_cmds);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
